@@ hdl/hwmed_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the HSV window mask edge detector.
// Depends on nothing; every other file of the block uses it by scoped names.
package hwmed_pkg;

  // Line store depth default
  localparam int DEF_MAX_LINE = 1024;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Reset geometry and height clamp
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [10:0] MAX_HEIGHT       = 11'd2046;

  // Output pixel levels and gradient threshold
  localparam logic [7:0] PIX_EDGE    = 8'd0;
  localparam logic [7:0] PIX_FLAT    = 8'd255;
  localparam int         EDGE_THRESH = 125;
  // A window holding both mask levels has a gradient of PIX_FLAT - PIX_EDGE
  localparam bit MIXED_IS_EDGE = (int'(PIX_FLAT) - int'(PIX_EDGE)) > EDGE_THRESH;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_HUE      = 3'd0,
    CFG_REF_SAT      = 3'd1,
    CFG_REF_VAL      = 3'd2,
    CFG_TOL_HUE      = 3'd3,
    CFG_TOL_SAT      = 3'd4,
    CFG_TOL_VAL      = 3'd5,
    CFG_FRAME_WIDTH  = 3'd6,
    CFG_FRAME_HEIGHT = 3'd7
  } cfg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  ref_hue;
    logic [7:0]  ref_sat;
    logic [7:0]  ref_val;
    logic [3:0]  tol_hue;
    logic [6:0]  tol_sat;
    logic [7:0]  tol_val;
    logic [10:0] frame_width;
    logic [10:0] frame_height;
  } cfg_t;

  // Control for one item on its way from the front stage to the window stage
  typedef struct packed {
    logic       clr;       // restart: clear window, no write, no result
    logic       wr;        // write the line store entry
    logic       emit;      // this item produces a result
    logic       last;      // result is the frame's last pixel
    logic       use_prev;  // judge the window as it was before this column
    logic       mask;      // mask bit of the incoming pixel
    logic [8:0] vmask;     // in-frame neighbours of the centre
  } item_t;

endpackage

@@ hdl/hwmed_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the HSV window mask edge detector.
// Depends on hwmed_pkg for the register indexes and the register set type.
module hwmed_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hwmed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hwmed_pkg::CFG_DATA_W-1:0] cfg_data,
  output hwmed_pkg::cfg_t                  cfg
);

  hwmed_pkg::cfg_t cfg_r;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Update the addressed register on each write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r              <= '0;
      cfg_r.frame_width  <= hwmed_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height <= hwmed_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      unique case (hwmed_pkg::cfg_idx_t'(cfg_index))
        hwmed_pkg::CFG_REF_HUE:      cfg_r.ref_hue      <= cfg_data[7:0];
        hwmed_pkg::CFG_REF_SAT:      cfg_r.ref_sat      <= cfg_data[7:0];
        hwmed_pkg::CFG_REF_VAL:      cfg_r.ref_val      <= cfg_data[7:0];
        hwmed_pkg::CFG_TOL_HUE:      cfg_r.tol_hue      <= cfg_data[3:0];
        hwmed_pkg::CFG_TOL_SAT:      cfg_r.tol_sat      <= cfg_data[6:0];
        hwmed_pkg::CFG_TOL_VAL:      cfg_r.tol_val      <= cfg_data[7:0];
        hwmed_pkg::CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[10:0];
        hwmed_pkg::CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[10:0];
        default:                     cfg_r              <= cfg_r;
      endcase
    end
  end

endmodule

@@ hdl/hwmed_line_mem.sv @@
`timescale 1ns / 1ps
// Two-bit-wide line store: bit 1 holds the previous mask row, bit 0 the row before it.
// One write and one registered read per cycle, with write-to-read forwarding.
module hwmed_line_mem #(
  parameter int DEPTH = hwmed_pkg::DEF_MAX_LINE
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [1:0]               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  assign rd_data = rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; take the word being written in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

endmodule

@@ hdl/hwmed_front.sv @@
`timescale 1ns / 1ps
// Front stage: raster position counters, color window test and window geometry.
// Depends on hwmed_pkg for the configuration set and the item control struct.
module hwmed_front #(
  parameter int MAX_LINE = hwmed_pkg::DEF_MAX_LINE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hwmed_pkg::cfg_t             cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [7:0]                  in_hue,
  input  logic [7:0]                  in_sat,
  input  logic [7:0]                  in_val,
  input  logic                        s1_free,
  output logic                        load,
  output hwmed_pkg::item_t            item,
  output logic [$clog2(MAX_LINE)-1:0] addr
);

  localparam int AW   = $clog2(MAX_LINE);
  localparam int WLEN = $clog2(MAX_LINE + 1);
  localparam int CMPW = ((WLEN > 11) ? WLEN : 11) + 1;

  // Strictly inside (r - t, r + t)
  function automatic logic inside_win(input logic [7:0] x, input logic [7:0] r,
                                      input logic [7:0] t);
    logic [8:0] xt;
    logic [8:0] rt;
    xt = {1'b0, x} + {1'b0, t};
    rt = {1'b0, r} + {1'b0, t};
    return ({1'b0, x} < rt) && (xt > {1'b0, r});
  endfunction

  logic [AW-1:0]   col_r, col_nxt;
  logic [11:0]     row_r, row_nxt;
  logic [CMPW-1:0] fw, w_eff, col_inc;
  logic [10:0]     h_eff;
  logic [11:0]     h_ext, h1;
  logic            wrap0, restart, in_frame, drop, accept, c_zero;
  logic [AW-1:0]   c0;
  logic [11:0]     r0;
  logic [2:0]      colv, rowv;
  logic            emit, last, use_prev, mask;
  logic [8:0]      vmask;

  // Clamp the frame geometry
  always_comb begin
    fw = CMPW'(cfg.frame_width);
    if (fw == '0) begin
      w_eff = CMPW'(1);
    end else if (fw > CMPW'(MAX_LINE)) begin
      w_eff = CMPW'(MAX_LINE);
    end else begin
      w_eff = fw;
    end
    if (cfg.frame_height == 11'd0) begin
      h_eff = 11'd1;
    end else if (cfg.frame_height > hwmed_pkg::MAX_HEIGHT) begin
      h_eff = hwmed_pkg::MAX_HEIGHT;
    end else begin
      h_eff = cfg.frame_height;
    end
    h_ext = {1'b0, h_eff};
    h1    = h_ext + 12'd1;
  end

  // Position of the incoming item and its classification
  always_comb begin
    wrap0    = CMPW'(col_r) >= w_eff;
    c0       = wrap0 ? '0 : col_r;
    r0       = wrap0 ? (row_r + 12'd1) : row_r;
    restart  = r0 > h1;
    in_frame = r0 < h_ext;
    drop     = !restart && in_frame && in_kind;
    mask     = in_frame
               && inside_win(in_hue, cfg.ref_hue, {4'd0, cfg.tol_hue})
               && inside_win(in_sat, cfg.ref_sat, {1'b0, cfg.tol_sat})
               && inside_win(in_val, cfg.ref_val, cfg.tol_val);
    c_zero   = (c0 == '0);
    if (c_zero) begin
      // centre is the last pixel of the row two above
      emit     = r0 >= 12'd2;
      colv     = {1'b1, (w_eff > CMPW'(1)), 1'b0};
      rowv     = {(r0 < h1), 1'b1, (r0 >= 12'd3)};
      last     = emit && (r0 == h1);
      use_prev = 1'b1;
    end else begin
      // centre is one row up and one column left
      emit     = r0 >= 12'd1;
      colv     = {1'b1, 1'b1, (CMPW'(c0) >= CMPW'(2))};
      rowv     = {in_frame, 1'b1, (r0 >= 12'd2)};
      last     = 1'b0;
      use_prev = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        vmask[3*i+j] = colv[i] && rowv[j];
      end
    end
  end

  // Hand the item to the window stage
  always_comb begin
    accept        = in_valid && s1_free;
    in_stall      = !s1_free;
    load          = accept && !drop;
    addr          = c0;
    item.clr      = restart;
    item.wr       = !restart;
    item.emit     = !restart && emit;
    item.last     = !restart && last;
    item.use_prev = use_prev;
    item.mask     = mask;
    item.vmask    = vmask;
  end

  // Advance the raster position
  always_comb begin
    col_inc = CMPW'(c0) + CMPW'(1);
    if (restart || last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (drop) begin
      col_nxt = c0;
      row_nxt = r0;
    end else if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r0 + 12'd1;
    end else begin
      col_nxt = AW'(col_inc);
      row_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ hdl/hwmed_window.sv @@
`timescale 1ns / 1ps
// Window stage: 3x3 mask window, line store write-back, edge decision, result register.
// Depends on hwmed_pkg for the item control struct and the output levels.
module hwmed_window #(
  parameter int MAX_LINE = hwmed_pkg::DEF_MAX_LINE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  hwmed_pkg::item_t            item,
  input  logic [$clog2(MAX_LINE)-1:0] addr,
  input  logic [1:0]                  rd_data,
  output logic                        s1_free,
  output logic                        wr_en,
  output logic [$clog2(MAX_LINE)-1:0] wr_addr,
  output logic [1:0]                  wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_pixel_out,
  output logic                        out_end_of_frame
);

  localparam int AW = $clog2(MAX_LINE);

  logic             s1_valid_r;
  hwmed_pkg::item_t s1_item_r;
  logic [AW-1:0]    s1_addr_r;
  logic [8:0]       win_r;
  logic             out_valid_r;
  logic [7:0]       pix_r;
  logic             eof_r;

  logic       out_free, s1_move, hit1, hit0, edge_det;
  logic [2:0] col;
  logic [8:0] new_win, win_used;

  // Pipeline flow: stage holds while its result cannot enter a full output register
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s1_move  = s1_valid_r && (!s1_item_r.emit || out_free);
    s1_free  = !s1_valid_r || s1_move;
  end

  // Shift the new column into the window and judge the centre
  always_comb begin
    col      = {s1_item_r.mask, rd_data[1], rd_data[0]};
    new_win  = {col, win_r[8:3]};
    win_used = s1_item_r.use_prev ? win_r : new_win;
    hit1     = |(win_used & s1_item_r.vmask);
    hit0     = |(~win_used & s1_item_r.vmask);
    edge_det = hit1 && hit0 && hwmed_pkg::MIXED_IS_EDGE;
  end

  // Age the line store entry: previous row moves down, new mask bit on top
  assign wr_en   = s1_move && s1_item_r.wr;
  assign wr_addr = s1_addr_r;
  assign wr_data = {s1_item_r.mask, rd_data[1]};

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= item;
      s1_addr_r <= addr;
    end
  end

  // Window register; clear at frame end or restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_move) begin
      win_r <= (s1_item_r.clr || s1_item_r.last) ? 9'd0 : new_win;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_move && s1_item_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_item_r.emit) begin
      pix_r <= edge_det ? hwmed_pkg::PIX_EDGE : hwmed_pkg::PIX_FLAT;
      eof_r <= s1_item_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = pix_r;
  assign out_end_of_frame = eof_r;

endmodule

@@ hdl/hsv_window_mask_edge_detect_unit.sv @@
`timescale 1ns / 1ps
// Top level of the HSV window mask edge detector.
// Depends on hwmed_pkg, hwmed_cfg_regs, hwmed_front, hwmed_line_mem and hwmed_window.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one HSV pixel per transaction in
//   raster order; in_kind = 1 marks a flush item. After the last pixel of a frame,
//   send frame_width + 1 flush items to drain the last row of results.
//   Output channel (out_valid / out_stall) carries one edge result per centre pixel:
//   out_pixel_out is 0 on an edge and 255 elsewhere, out_end_of_frame marks the
//   frame's last pixel. Results lag the pixel stream by one line plus one pixel.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the reference
//   color, tolerances and frame size; write it only while the block is idle.
// Timing:
//   One transaction per cycle sustained. The line store is read as a transaction is
//   taken; its result is registered in the window stage, then in the output register.
//   When out_stall holds a result, one more result-producing transaction is taken
//   into the window stage; further input is then stalled until the result is taken.
// Reset:
//   rst_n clears the counters, window and pipeline; geometry returns to 640 x 480.
//   Line store contents are not cleared; rows outside the frame are never used.
module hsv_window_mask_edge_detect_unit #(
  parameter int MAX_LINE = hwmed_pkg::DEF_MAX_LINE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [7:0]                       in_hue,
  input  logic [7:0]                       in_sat,
  input  logic [7:0]                       in_val,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_pixel_out,
  output logic                             out_end_of_frame,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hwmed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hwmed_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_LINE);

  hwmed_pkg::cfg_t  cfg;
  hwmed_pkg::item_t item;
  logic             load, s1_free, wr_en;
  logic [AW-1:0]    addr, wr_addr;
  logic [1:0]       rd_data, wr_data;

  // Configuration registers
  hwmed_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Position tracking and color classification
  hwmed_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_hue   (in_hue),
    .in_sat   (in_sat),
    .in_val   (in_val),
    .s1_free  (s1_free),
    .load     (load),
    .item     (item),
    .addr     (addr)
  );

  // Mask line stores, read as the item enters the window stage
  hwmed_line_mem #(
    .DEPTH (MAX_LINE)
  ) u_lines (
    .clk     (clk),
    .rd_en   (load),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Window, edge decision and result register
  hwmed_window #(
    .MAX_LINE (MAX_LINE)
  ) u_window (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .item             (item),
    .addr             (addr),
    .rd_data          (rd_data),
    .s1_free          (s1_free),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
